// ===== rtl/sptq_pkg.sv =====
// ----------------------------------------------------------------------------
// sptq_pkg
// Shared types, field widths and codes for the slot priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sptq_pkg;

	// Default sizing of the slot table.
	localparam int SLOTS_DEF       = 16;
	localparam int PRIO_LEVELS_DEF = 8;

	// Fixed field widths.
	localparam int PRIO_W   = 8;
	localparam int HANDLE_W = 32;
	localparam int ARG_W    = 32;
	localparam int SEQ_W    = 32;
	localparam int OCC_W    = 5;
	localparam int ENTRY_W  = PRIO_W + SEQ_W + HANDLE_W + ARG_W;

	// Stream widths.
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 80;

	// Command codes carried in the input tuser.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_PRIORITY = 2'd1,
		ST_FULL         = 2'd2,
		ST_EMPTY        = 2'd3
	} status_t;

	// One request beat.
	typedef struct packed {
		logic                cmd;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
		logic [ARG_W-1:0]    arg;
	} req_t;

	// One result beat.
	typedef struct packed {
		status_t             status;
		logic [PRIO_W-1:0]   prio;
		logic [HANDLE_W-1:0] handle;
		logic [ARG_W-1:0]    arg;
		logic [OCC_W-1:0]    occupancy;
		logic                is_empty;
	} result_t;

	// Slot table entry as stored in RAM.
	typedef struct packed {
		logic [PRIO_W-1:0]   prio;
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
		logic [ARG_W-1:0]    arg;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/sptq_ram.sv =====
// ----------------------------------------------------------------------------
// sptq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sptq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sptq_engine.sv =====
// ----------------------------------------------------------------------------
// sptq_engine
// Sequencer that walks the slot table one entry per cycle, for free-slot search
// and best-task pop; a pop feeds a single priority/sequence comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module sptq_engine #(
	parameter int SLOTS       = sptq_pkg::SLOTS_DEF,
	parameter int PRIO_LEVELS = sptq_pkg::PRIO_LEVELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sptq_pkg::req_t    req,
	output logic                   idle,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output sptq_pkg::result_t      res
);

	localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int KEY_W   = sptq_pkg::PRIO_W + sptq_pkg::SEQ_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
	localparam logic [sptq_pkg::SEQ_W-1:0] SEQ_ONE = 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_SCAN,
		S_DRAIN,
		S_POPFIN,
		S_DONE
	} state_t;

	state_t                          state_q;
	sptq_pkg::req_t                  req_q;
	logic [IDX_W-1:0]                idx_q;
	logic [SLOTS-1:0]                valid_q;
	logic [CNT_W-1:0]                occ_q;
	logic [sptq_pkg::SEQ_W-1:0]      seq_q;
	sptq_pkg::status_t               status_q;
	logic [sptq_pkg::PRIO_W-1:0]     out_prio_q;
	logic [sptq_pkg::HANDLE_W-1:0]   out_handle_q;
	logic [sptq_pkg::ARG_W-1:0]      out_arg_q;

	// Scan pipeline and running best entry.
	logic                            rd_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            found_q;
	logic [KEY_W-1:0]                best_key_q;
	logic [IDX_W-1:0]                best_idx_q;
	logic [sptq_pkg::HANDLE_W-1:0]   best_handle_q;
	logic [sptq_pkg::ARG_W-1:0]      best_arg_q;

	sptq_pkg::entry_t                wr_entry;
	sptq_pkg::entry_t                rd_entry;
	logic [sptq_pkg::ENTRY_W-1:0]    rd_word;
	logic                            ram_we;
	logic                            ram_re;
	logic [KEY_W-1:0]                rd_key;
	logic                            take;
	logic                            bad_prio;
	logic [CNT_W+sptq_pkg::OCC_W-1:0] occ_ext;

	// Slot payload storage.
	sptq_ram #(
		.WIDTH(sptq_pkg::ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(rd_word)
	);

	// Write the pushed entry into the first free slot found.
	always_comb begin
		wr_entry.prio   = req_q.prio;
		wr_entry.seq    = seq_q;
		wr_entry.handle = req_q.handle;
		wr_entry.arg    = req_q.arg;
		ram_we = (state_q == S_FIND) && !valid_q[idx_q];
		ram_re = (state_q == S_SCAN);
	end

	// Single comparator: does the entry just read beat the best so far?
	always_comb begin
		rd_entry = rd_word;
		rd_key   = {rd_entry.prio, rd_entry.seq};
		take     = rd_s1 && valid_q[idx_s1] && (!found_q || (rd_key < best_key_q));
		bad_prio = {1'b0, req.prio} >= 9'(PRIO_LEVELS);
	end

	// Result view; occupancy is taken from the live counter.
	always_comb begin
		occ_ext       = {{sptq_pkg::OCC_W{1'b0}}, occ_q};
		idle          = (state_q == S_IDLE);
		res_valid     = (state_q == S_DONE);
		res.status    = status_q;
		res.prio      = out_prio_q;
		res.handle    = out_handle_q;
		res.arg       = out_arg_q;
		res.occupancy = occ_ext[sptq_pkg::OCC_W-1:0];
		res.is_empty  = (occ_q == '0);
	end

	// Sequencer, slot state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			idx_q         <= '0;
			valid_q       <= '0;
			occ_q         <= '0;
			seq_q         <= '0;
			status_q      <= sptq_pkg::ST_OK;
			out_prio_q    <= '0;
			out_handle_q  <= '0;
			out_arg_q     <= '0;
			rd_s1         <= 1'b0;
			idx_s1        <= '0;
			found_q       <= 1'b0;
			best_key_q    <= '0;
			best_idx_q    <= '0;
			best_handle_q <= '0;
			best_arg_q    <= '0;
		end else begin
			rd_s1  <= ram_re;
			idx_s1 <= idx_q;

			if (take) begin
				found_q       <= 1'b1;
				best_key_q    <= rd_key;
				best_idx_q    <= idx_s1;
				best_handle_q <= rd_entry.handle;
				best_arg_q    <= rd_entry.arg;
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q        <= req;
						idx_q        <= '0;
						found_q      <= 1'b0;
						status_q     <= sptq_pkg::ST_OK;
						out_prio_q   <= '0;
						out_handle_q <= '0;
						out_arg_q    <= '0;
						if (req.cmd == sptq_pkg::CMD_PUSH) begin
							if (bad_prio) begin
								status_q <= sptq_pkg::ST_BAD_PRIORITY;
								state_q  <= S_DONE;
							end else if (occ_q == FULL_CNT) begin
								status_q <= sptq_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_FIND;
							end
						end else begin
							if (occ_q == '0) begin
								status_q <= sptq_pkg::ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_FIND: begin
					// A free slot is known to exist since the table is not full.
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= (req_q.handle != '0);
						occ_q   <= occ_q + CNT_W'(req_q.handle != '0);
						seq_q   <= seq_q + SEQ_ONE;
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					// The last slot read is compared on this edge.
					state_q <= S_POPFIN;
				end
				S_POPFIN: begin
					valid_q[best_idx_q] <= 1'b0;
					occ_q        <= occ_q - CNT_W'(1);
					out_prio_q   <= best_key_q[KEY_W-1 -: sptq_pkg::PRIO_W];
					out_handle_q <= best_handle_q;
					out_arg_q    <= best_arg_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/slot_priority_task_queue_core.sv =====
// ----------------------------------------------------------------------------
// slot_priority_task_queue_core
// Priority task queue over a fixed table of task slots.
//
// Input stream: one beat per command. tuser carries the command (push or
// pop); tdata carries priority, task handle and argument. Output stream: one
// beat per command with a status code in tuser and the popped task, the
// occupancy and an empty flag in tdata.
// A push walks the valid bits from slot 0 to the first free slot, one slot a
// cycle. A pop reads every slot from the RAM once through a single
// priority/sequence comparator. Rejected commands (bad priority, full,
// empty) skip the search and go straight to the result. One command is in
// work at a time; s_axis_tready is low while the sequencer is busy.
// The output register holds a finished beat while m_axis_tready is low; the
// sequencer can take and run the next command meanwhile and waits with its
// result until the register frees up.
// Reset empties the table and clears the sequence counter; no clearing pass
// is needed since slot contents are only used while valid.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_priority_task_queue_core #(
	parameter int SLOTS       = sptq_pkg::SLOTS_DEF,
	parameter int PRIO_LEVELS = sptq_pkg::PRIO_LEVELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input beats.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// tdata: priority_req[7:0], task_handle[39:8], task_arg[71:40].
	input  wire logic [sptq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: command[0].
	input  wire logic                             s_axis_tuser,
	// Output beats.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// tdata: out_priority[7:0], out_handle[39:8], out_arg[71:40],
	// occupancy[76:72], is_empty[77], zero fill[79:78].
	output logic      [sptq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// tuser: status[1:0].
	output logic      [1:0]                       m_axis_tuser
);

	sptq_pkg::req_t    req;
	sptq_pkg::result_t res;
	sptq_pkg::result_t out_q;
	logic              out_valid_q;
	logic              eng_idle;
	logic              res_valid;
	logic              res_ready;
	logic              start;

	// Unpack the input beat.
	always_comb begin
		req.cmd    = s_axis_tuser;
		req.prio   = s_axis_tdata[7:0];
		req.handle = s_axis_tdata[39:8];
		req.arg    = s_axis_tdata[71:40];
		s_axis_tready = eng_idle;
		start      = s_axis_tvalid && eng_idle;
		res_ready  = !out_valid_q || m_axis_tready;
	end

	sptq_engine #(
		.SLOTS      (SLOTS),
		.PRIO_LEVELS(PRIO_LEVELS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.idle     (eng_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register between the sequencer and the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pack the output beat.
	always_comb begin
		m_axis_tvalid = out_valid_q;
		m_axis_tuser  = out_q.status;
		m_axis_tdata  = {2'b00, out_q.is_empty, out_q.occupancy,
			out_q.arg, out_q.handle, out_q.prio};
	end

endmodule

`default_nettype wire

// ===== dv/sptq_monitor.sv =====
// ----------------------------------------------------------------------------
// sptq_monitor
// Watches both beat channels of the slot priority task queue, keeps its own
// slot table to work out the answer to every accepted command, and compares
// each output beat field by field against the oldest answer still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module sptq_monitor
	import sptq_pkg::*;
#(
	parameter int SLOTS       = SLOTS_DEF,
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                   s_axis_tuser,
	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  wire logic [1:0]             m_axis_tuser,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the slot table and the sequence counter.
	logic [SLOTS-1:0]    live;
	logic [PRIO_W-1:0]   task_prio [SLOTS];
	logic [SEQ_W-1:0]    task_seq [SLOTS];
	logic [HANDLE_W-1:0] task_handle [SLOTS];
	logic [ARG_W-1:0]    task_arg [SLOTS];
	logic [SEQ_W-1:0]    seq_counter;

	// Answers owed by the block, oldest first.
	result_t             owed_answers[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	task automatic report(string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s is 0x%0h, should be 0x%0h", name, got, want));
		end
	endtask

	// Applies one command to the shadow table and returns the answer it owes.
	function automatic result_t run_command(logic cmd, logic [PRIO_W-1:0] prio,
			logic [HANDLE_W-1:0] handle, logic [ARG_W-1:0] arg);
		result_t ans;
		int      free_slot;
		int      best;
		int      count;
		ans = '0;
		ans.status = ST_OK;
		free_slot = -1;
		best = -1;
		if (cmd == CMD_PUSH) begin
			// Range check comes ahead of the full check.
			if (prio >= PRIO_LEVELS) begin
				ans.status = ST_BAD_PRIORITY;
			end else begin
				for (int i = SLOTS - 1; i >= 0; i--) begin
					if (!live[i]) begin
						free_slot = i;
					end
				end
				if (free_slot < 0) begin
					ans.status = ST_FULL;
				end else begin
					// A zero handle still uses up a sequence number but leaves
					// the slot free.
					task_prio[free_slot] = prio;
					task_handle[free_slot] = handle;
					task_arg[free_slot] = arg;
					task_seq[free_slot] = seq_counter;
					live[free_slot] = (handle != '0);
					seq_counter = seq_counter + 1'b1;
				end
			end
		end else begin
			// Lowest priority number wins, then lowest sequence, then lowest slot.
			for (int i = 0; i < SLOTS; i++) begin
				if (live[i]) begin
					if (best < 0 || task_prio[i] < task_prio[best] ||
							(task_prio[i] == task_prio[best] &&
							task_seq[i] < task_seq[best])) begin
						best = i;
					end
				end
			end
			if (best < 0) begin
				ans.status = ST_EMPTY;
			end else begin
				ans.prio = task_prio[best];
				ans.handle = task_handle[best];
				ans.arg = task_arg[best];
				live[best] = 1'b0;
			end
		end
		count = $countones(live);
		ans.occupancy = count[OCC_W-1:0];
		ans.is_empty = (count == 0);
		return ans;
	endfunction

	// Output beats are compared before the input beat of the same edge is
	// predicted, since an answer never leaves on the edge its command enters.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			live = '0;
			seq_counter = '0;
			owed_answers.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.prio = m_axis_tdata[7:0];
				got.handle = m_axis_tdata[39:8];
				got.arg = m_axis_tdata[71:40];
				got.occupancy = m_axis_tdata[76:72];
				got.is_empty = m_axis_tdata[77];
				if (owed_answers.size() == 0) begin
					report("output beat with no command waiting for it");
				end else begin
					want = owed_answers.pop_front();
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("out_priority", 32'(got.prio), 32'(want.prio));
					check_field("out_handle", got.handle, want.handle);
					check_field("out_arg", got.arg, want.arg);
					check_field("occupancy", 32'(got.occupancy), 32'(want.occupancy));
					check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
					check_field("tdata fill", 32'(m_axis_tdata[79:78]), 32'd0);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				owed_answers.push_back(run_command(s_axis_tuser, s_axis_tdata[7:0],
					s_axis_tdata[39:8], s_axis_tdata[71:40]));
			end
			pending = owed_answers.size();
		end
	end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives push and pop beats into the slot priority task queue: a short
// directed opening over the edge cases, then random fill and drain episodes
// mixed with rejected and malformed commands, with random gaps on the input
// and random stalls on the output. The monitor does all checking.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sptq_pkg::*;

	localparam int ITEMS      = 900;
	localparam int CALM_AFTER = 780;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = CMD_PUSH;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	int                     errors;
	int                     pending;

	// Stimulus bookkeeping shared with the output stall process.
	int                     sent = 0;
	bit                     calm = 1'b0;
	int                     gap_odds = 0;

	slot_priority_task_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	sptq_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending)
	);

	// Clock generation.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Output side: ready runs of random length broken by stall bursts.
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(40, 200)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Presents one beat, holds it until accepted, then maybe leaves a gap.
	// Valid is only lowered when a gap follows, so back-to-back beats keep it high.
	task automatic send(logic cmd, logic [PRIO_W-1:0] prio, logic [HANDLE_W-1:0] handle,
			logic [ARG_W-1:0] arg);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {arg, handle, prio};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Pop beats carry random junk in the unused fields.
	task automatic pop_best();
		send(CMD_POP, PRIO_W'($urandom), $urandom, $urandom);
	endtask

	// Mostly well-formed pushes, with some zero handles and bad priorities.
	task automatic push_random(int levels);
		int               pick;
		logic [HANDLE_W-1:0] handle;
		pick = $urandom_range(0, 99);
		handle = $urandom;
		if (handle == '0) begin
			handle = 32'd1;
		end
		if (pick < 4) begin
			send(CMD_PUSH, PRIO_W'($urandom_range(0, levels - 1)), '0, $urandom);
		end else if (pick < 10) begin
			send(CMD_PUSH, PRIO_W'($urandom_range(PRIO_LEVELS_DEF, 255)), handle, $urandom);
		end else begin
			send(CMD_PUSH, PRIO_W'($urandom_range(0, levels - 1)), handle, $urandom);
		end
	endtask

	initial begin
		int batch;
		int levels;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty pop, out-of-range priorities, field extremes,
		// a zero handle that must not stay queued, then a full table with ties.
		pop_best();
		send(CMD_PUSH, 8'd8, 32'h1234_5678, 32'h0);
		send(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_PUSH, 8'd7, 32'h0000_0001, 32'hFFFF_FFFF);
		send(CMD_PUSH, 8'd0, 32'hFFFF_FFFF, 32'h0);
		send(CMD_PUSH, 8'd3, 32'h0, 32'hA5A5_5A5A);
		pop_best();
		pop_best();
		pop_best();
		for (int i = 0; i < SLOTS_DEF; i++) begin
			send(CMD_PUSH, PRIO_W'((i % 3) * 3), 32'h100 + i, $urandom);
		end
		send(CMD_PUSH, 8'd2, 32'hDEAD_BEEF, 32'h1);
		send(CMD_PUSH, 8'd200, 32'hDEAD_BEEF, 32'h2);

		// Random episodes: mostly fill then drain, some noise.
		while (sent < ITEMS) begin
			calm = (sent >= CALM_AFTER);
			gap_odds = $urandom_range(0, 3);
			levels = ($urandom_range(0, 2) == 0) ? 2 : PRIO_LEVELS_DEF;
			if ($urandom_range(0, 9) < 7) begin
				batch = $urandom_range(1, 20);
				repeat (batch) push_random(levels);
				repeat ($urandom_range(1, batch + 2)) pop_best();
			end else begin
				repeat ($urandom_range(1, 10)) begin
					case ($urandom_range(0, 3))
						0: send(CMD_PUSH, PRIO_W'($urandom_range(PRIO_LEVELS_DEF, 255)),
							$urandom, $urandom);
						1: send(CMD_PUSH, PRIO_W'($urandom_range(0, PRIO_LEVELS_DEF - 1)),
							'0, $urandom);
						2: pop_best();
						default: send(1'($urandom), PRIO_W'($urandom), $urandom, $urandom);
					endcase
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// Drain what is still owed, then let the pipeline settle.
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== slot_priority_task_queue_core.f =====
rtl/sptq_pkg.sv
rtl/sptq_ram.sv
rtl/sptq_engine.sv
rtl/slot_priority_task_queue_core.sv
dv/sptq_monitor.sv
dv/testbench.sv
